// ===== hdl/apngp_pkg.sv =====
// Package for the APNG chunk stream parser: result word type, chunk codes and constants.
// No dependencies.
package apngp_pkg;

   localparam logic [7:0] SIG_B0 = 8'h89;
   localparam logic [7:0] SIG_B1 = 8'h50;
   localparam logic [7:0] SIG_B2 = 8'h4E;
   localparam logic [7:0] SIG_B3 = 8'h47;
   localparam logic [7:0] SIG_B4 = 8'h0D;
   localparam logic [7:0] SIG_B5 = 8'h0A;
   localparam logic [7:0] SIG_B6 = 8'h1A;
   localparam logic [7:0] SIG_B7 = 8'h0A;

   localparam logic [31:0] T_IHDR = 32'h49484452;
   localparam logic [31:0] T_ACTL = 32'h6163544C;
   localparam logic [31:0] T_FCTL = 32'h6663544C;
   localparam logic [31:0] T_IDAT = 32'h49444154;
   localparam logic [31:0] T_FDAT = 32'h66644154;
   localparam logic [31:0] T_IEND = 32'h49454E44;

   localparam logic [16:0] MAX_FRAMES_RESET = 17'd100000;
   localparam logic [31:0] IHDR_LEN = 32'd13;
   localparam logic [31:0] ACTL_LEN = 32'd8;
   localparam logic [31:0] FCTL_LEN = 32'd26;

   localparam logic [1:0] EV_DESC = 2'd0;
   localparam logic [1:0] EV_DATA = 2'd1;
   localparam logic [1:0] EV_SUMMARY = 2'd2;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_UNSUP = 2'd1;
   localparam logic [1:0] ST_CORRUPT = 2'd2;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW = 2;

   typedef struct packed {
      logic [1:0] event_kind;
      logic [16:0] frame_number;
      logic [31:0] region_width;
      logic [31:0] region_height;
      logic [31:0] offset_x;
      logic [31:0] offset_y;
      logic [15:0] delay_numerator;
      logic [15:0] delay_denominator;
      logic [2:0] dispose_and_blend;
      logic [7:0] payload_byte;
      logic [1:0] parse_status;
      logic run_last;
   } result_type;

   // one parse step's output: up to two results
   typedef struct packed {
      logic first_valid;
      logic second_valid;
      result_type first;
      result_type second;
   } step_type;

endpackage

// ===== hdl/apngp_if.sv =====
// Valid/ready channel interfaces: file bytes in on apngp_req_if, result words out on apngp_rsp_if.
// Depends on apngp_pkg for payload types.
interface apngp_req_if;
   logic valid;
   logic ready;
   logic [7:0] file_byte;
   logic end_of_file;
   modport source (output valid, file_byte, end_of_file, input ready);
   modport sink (input valid, file_byte, end_of_file, output ready);
endinterface

interface apngp_rsp_if import apngp_pkg::*;;
   logic valid;
   logic ready;
   result_type payload;
   modport source (output valid, payload, input ready);
   modport sink (input valid, payload, output ready);
endinterface

// ===== hdl/apngp_front.sv =====
// Front part: parses one byte per cycle and produces up to two results per byte.
// Depends on apngp_pkg.
module apngp_front import apngp_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic [16:0] max_frames,
   input  logic in_valid,
   input  logic [7:0] in_byte,
   input  logic in_eof,
   output step_type step_out
);

   logic [3:0] sig_ff, sig_in;
   logic [32:0] cnt_ff, cnt_in;
   logic [31:0] len_ff, len_in;
   logic [31:0] kind_ff, kind_in;
   logic [31:0] shift_ff, shift_in;
   logic [31:0] pw_ff, pw_in, ph_ff, ph_in, px_ff, px_in, py_ff, py_in;
   logic [15:0] dnum_ff, dnum_in, dden_ff, dden_in;
   logic [7:0] dsp_ff, dsp_in, bld_ff, bld_in;
   logic [31:0] cw_ff, cw_in, ch_ff, ch_in;
   logic [31:0] loop_ff, loop_in, decl_ff, decl_in, eseq_ff, eseq_in;
   logic [16:0] fseen_ff, fseen_in;
   logic f_ihdr_ff, f_ihdr_in, f_actl_ff, f_actl_in, f_idat_ff, f_idat_in;
   logic f_idf_ff, f_idf_in, f_has_ff, f_has_in, f_miss_ff, f_miss_in;
   logic f_done_ff, f_done_in, f_fwd_ff, f_fwd_in;
   logic [1:0] err_ff, err_in;
   step_type step_in;

   logic [7:0] sig_exp;
   logic [32:0] pos;
   logic [32:0] d;
   logic [31:0] v;
   logic [32:0] sx, sy;
   logic desc_v;
   result_type desc, dat, summ;
   logic data_v;
   logic [1:0] fstat;

   always_comb begin
      case (sig_ff[2:0])
         3'd0: sig_exp = SIG_B0;
         3'd1: sig_exp = SIG_B1;
         3'd2: sig_exp = SIG_B2;
         3'd3: sig_exp = SIG_B3;
         3'd4: sig_exp = SIG_B4;
         3'd5: sig_exp = SIG_B5;
         3'd6: sig_exp = SIG_B6;
         default: sig_exp = SIG_B7;
      endcase
   end

   always_comb begin
      sig_in = sig_ff; cnt_in = cnt_ff; len_in = len_ff; kind_in = kind_ff;
      shift_in = shift_ff; pw_in = pw_ff; ph_in = ph_ff; px_in = px_ff; py_in = py_ff;
      dnum_in = dnum_ff; dden_in = dden_ff; dsp_in = dsp_ff; bld_in = bld_ff;
      cw_in = cw_ff; ch_in = ch_ff; loop_in = loop_ff; decl_in = decl_ff;
      eseq_in = eseq_ff; fseen_in = fseen_ff;
      f_ihdr_in = f_ihdr_ff; f_actl_in = f_actl_ff; f_idat_in = f_idat_ff;
      f_idf_in = f_idf_ff; f_has_in = f_has_ff; f_miss_in = f_miss_ff;
      f_done_in = f_done_ff; f_fwd_in = f_fwd_ff; err_in = err_ff;
      pos = cnt_ff; d = cnt_ff - 33'd8; v = '0; sx = '0; sy = '0;
      desc_v = 1'b0; data_v = 1'b0; desc = '0; dat = '0; summ = '0; fstat = ST_OK;

      if (in_valid && err_ff == ST_OK && !f_done_ff) begin
         if (sig_ff < 4'd8) begin
            if (in_byte != sig_exp) err_in = ST_UNSUP;
            else sig_in = sig_ff + 4'd1;
         end else begin
            shift_in = {shift_ff[23:0], in_byte};
            v = shift_in;
            if (pos == 33'd3) len_in = v;
            if (pos == 33'd7) begin
               kind_in = v;
               f_fwd_in = f_ihdr_ff && v == T_IDAT && f_actl_ff && f_idf_ff
                          && fseen_ff != '0;
            end
            if (pos >= 33'd8 && pos < 33'd8 + {1'b0, len_ff}) begin
               if (f_fwd_ff) begin
                  data_v = 1'b1;
                  dat.event_kind = EV_DATA;
                  dat.frame_number = fseen_ff - 17'd1;
                  dat.payload_byte = in_byte;
               end else if (!f_ihdr_ff) begin
                  if (d == 33'd3) cw_in = v;
                  if (d == 33'd7) begin
                     ch_in = v;
                     if (cw_ff == '0 || v == '0) err_in = ST_CORRUPT;
                     else f_ihdr_in = 1'b1;
                  end
               end else if (kind_ff == T_ACTL) begin
                  if (d == 33'd3) decl_in = v;
                  if (d == 33'd7) begin
                     loop_in = v;
                     if (decl_ff == '0 || decl_ff > {15'd0, max_frames}) err_in = ST_CORRUPT;
                     else f_actl_in = 1'b1;
                  end
               end else if (kind_ff == T_FCTL) begin
                  case (d[4:0])
                     5'd7: if (d[32:5] == '0) pw_in = v;
                     5'd11: if (d[32:5] == '0) ph_in = v;
                     5'd15: if (d[32:5] == '0) px_in = v;
                     5'd19: if (d[32:5] == '0) py_in = v;
                     5'd21: if (d[32:5] == '0) begin
                        dnum_in = v[15:0]; dden_in = '0; dsp_in = '0; bld_in = '0;
                     end
                     5'd23: if (d[32:5] == '0) dden_in = v[15:0];
                     5'd24: if (d[32:5] == '0) dsp_in = v[7:0];
                     default: ;
                  endcase
                  if (d == 33'd25) begin
                     bld_in = v[7:0];
                     sx = {1'b0, px_ff} + {1'b0, pw_ff};
                     sy = {1'b0, py_ff} + {1'b0, ph_ff};
                     if (pw_ff == '0 || ph_ff == '0 || dsp_ff > 8'd2 || v[7:0] > 8'd1
                         || sx > {1'b0, cw_ff} || sy > {1'b0, ch_ff})
                        err_in = ST_CORRUPT;
                     else if (!f_idat_ff && (px_ff != '0 || py_ff != '0
                              || pw_ff != cw_ff || ph_ff != ch_ff))
                        err_in = ST_CORRUPT;
                     else if ({15'd0, fseen_ff} >= decl_ff)
                        err_in = ST_CORRUPT;
                     else begin
                        if (fseen_ff != '0 && !f_has_ff) f_miss_in = 1'b1;
                        f_has_in = 1'b0;
                        f_idf_in = !f_idat_ff;
                        desc_v = 1'b1;
                        desc.event_kind = EV_DESC;
                        desc.frame_number = fseen_ff;
                        desc.region_width = pw_ff;
                        desc.region_height = ph_ff;
                        desc.offset_x = px_ff;
                        desc.offset_y = py_ff;
                        desc.delay_numerator = dnum_ff;
                        desc.delay_denominator = dden_ff;
                        desc.dispose_and_blend = 3'(dsp_ff[1:0] * 2 + v[0]);
                        fseen_in = fseen_ff + 17'd1;
                     end
                  end
               end
            end
            cnt_in = pos + 33'd1;
            if (err_in == ST_OK && cnt_in == 33'd12) begin
               if (!f_ihdr_ff) begin
                  if (kind_ff != T_IHDR || len_ff != IHDR_LEN) err_in = ST_CORRUPT;
               end else if (kind_ff == T_ACTL) begin
                  if (len_ff != ACTL_LEN || f_actl_ff || f_idat_ff) err_in = ST_CORRUPT;
               end else if (kind_ff == T_FCTL) begin
                  if (!f_actl_ff || len_ff != FCTL_LEN || v != eseq_ff) err_in = ST_CORRUPT;
                  else eseq_in = eseq_ff + 32'd1;
               end else if (kind_ff == T_IDAT) begin
                  f_idat_in = 1'b1;
                  if (f_actl_ff && f_idf_ff && fseen_ff != '0) f_has_in = 1'b1;
                  f_idf_in = f_idf_ff && fseen_ff == 17'd1;
               end else if (kind_ff == T_FDAT) begin
                  if (!(f_actl_ff && f_idat_ff && len_ff >= 32'd4 && fseen_ff != '0
                        && !f_idf_ff)) err_in = ST_CORRUPT;
                  else if (v != eseq_ff) err_in = ST_CORRUPT;
                  else begin
                     eseq_in = eseq_ff + 32'd1; f_has_in = 1'b1; f_fwd_in = 1'b1;
                  end
               end
            end
            if (err_in == ST_OK && cnt_in == {1'b0, len_in} + 33'd12) begin
               if (f_ihdr_in && kind_in == T_IEND) f_done_in = 1'b1;
               f_fwd_in = 1'b0;
               cnt_in = '0;
            end
         end
      end

      if (err_in != ST_OK) fstat = err_in;
      else if (sig_in < 4'd8) fstat = ST_UNSUP;
      else if (cnt_in >= 33'd12) fstat = ST_CORRUPT;
      else if (!f_ihdr_in) fstat = ST_CORRUPT;
      else if (!f_actl_in) fstat = ST_UNSUP;
      else if (!f_idat_in || {15'd0, fseen_in} != decl_in) fstat = ST_CORRUPT;
      else if (f_miss_in || (fseen_in != '0 && !f_has_in)) fstat = ST_CORRUPT;
      summ.event_kind = EV_SUMMARY;
      summ.frame_number = fseen_in;
      summ.region_width = cw_in;
      summ.region_height = ch_in;
      summ.offset_x = loop_in;
      summ.parse_status = fstat;
      summ.run_last = 1'b1;

      step_in = '0;
      if (in_valid) begin
         if (desc_v || data_v) begin
            step_in.first_valid = 1'b1;
            step_in.first = desc_v ? desc : dat;
            if (in_eof) begin
               step_in.second_valid = 1'b1;
               step_in.second = summ;
            end else begin
               step_in.first.run_last = 1'b1;
            end
         end else if (in_eof) begin
            step_in.first_valid = 1'b1;
            step_in.first = summ;
         end
      end

      if (in_valid && in_eof) begin
         sig_in = '0; cnt_in = '0; len_in = '0; kind_in = '0; shift_in = '0;
         pw_in = '0; ph_in = '0; px_in = '0; py_in = '0;
         dnum_in = '0; dden_in = '0; dsp_in = '0; bld_in = '0;
         cw_in = '0; ch_in = '0; loop_in = '0; decl_in = '0; eseq_in = '0;
         fseen_in = '0; f_ihdr_in = 1'b0; f_actl_in = 1'b0; f_idat_in = 1'b0;
         f_idf_in = 1'b0; f_has_in = 1'b0; f_miss_in = 1'b0; f_done_in = 1'b0;
         f_fwd_in = 1'b0; err_in = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sig_ff <= '0; cnt_ff <= '0; len_ff <= '0; kind_ff <= '0; shift_ff <= '0;
         pw_ff <= '0; ph_ff <= '0; px_ff <= '0; py_ff <= '0;
         dnum_ff <= '0; dden_ff <= '0; dsp_ff <= '0; bld_ff <= '0;
         cw_ff <= '0; ch_ff <= '0; loop_ff <= '0; decl_ff <= '0; eseq_ff <= '0;
         fseen_ff <= '0; f_ihdr_ff <= 1'b0; f_actl_ff <= 1'b0; f_idat_ff <= 1'b0;
         f_idf_ff <= 1'b0; f_has_ff <= 1'b0; f_miss_ff <= 1'b0; f_done_ff <= 1'b0;
         f_fwd_ff <= 1'b0; err_ff <= ST_OK;
      end else if (in_valid) begin
         sig_ff <= sig_in; cnt_ff <= cnt_in; len_ff <= len_in; kind_ff <= kind_in;
         shift_ff <= shift_in; pw_ff <= pw_in; ph_ff <= ph_in; px_ff <= px_in;
         py_ff <= py_in; dnum_ff <= dnum_in; dden_ff <= dden_in; dsp_ff <= dsp_in;
         bld_ff <= bld_in; cw_ff <= cw_in; ch_ff <= ch_in; loop_ff <= loop_in;
         decl_ff <= decl_in; eseq_ff <= eseq_in; fseen_ff <= fseen_in;
         f_ihdr_ff <= f_ihdr_in; f_actl_ff <= f_actl_in; f_idat_ff <= f_idat_in;
         f_idf_ff <= f_idf_in; f_has_ff <= f_has_in; f_miss_ff <= f_miss_in;
         f_done_ff <= f_done_in; f_fwd_ff <= f_fwd_in; err_ff <= err_in;
      end
   end

   assign step_out = step_in;

endmodule

// ===== hdl/apngp_queue.sv =====
// Result queue between the parser and the output: takes up to two words a cycle.
// Depends on apngp_pkg.
module apngp_queue import apngp_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  step_type push,
   output logic room,
   output logic out_valid,
   input  logic out_ready,
   output result_type out_word
);

   result_type mem [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [QUEUE_AW:0] cnt_ff, cnt_in;
   logic pop;
   logic [1:0] npush;

   assign pop = out_valid && out_ready;
   assign npush = {1'b0, push.first_valid} + {1'b0, push.second_valid};
   assign out_valid = cnt_ff != '0;
   assign out_word = mem[rp_ff];
   // keep space for a full step
   assign room = cnt_ff <= (QUEUE_AW+1)'(QUEUE_DEPTH - 2);

   always_comb begin
      wp_in = wp_ff + QUEUE_AW'(npush);
      rp_in = rp_ff + QUEUE_AW'(pop);
      cnt_in = cnt_ff + (QUEUE_AW+1)'(npush) - (QUEUE_AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.first_valid) mem[wp_ff] <= push.first;
      if (push.second_valid) mem[wp_ff + QUEUE_AW'(1)] <= push.second;
   end

endmodule

// ===== hdl/apng_chunk_stream_parser_core.sv =====
// Results are written into the result queue registers and shown on rsp from there.
// Throughput: one byte per cycle; req is held only while three or more words wait
// in the four-word result queue, which happens only when rsp stalls.
// Reset: synchronous, active high; clears parse state and queue, max_frames to 100000.
// Depends on apngp_pkg, apngp_if, apngp_front, apngp_queue.
module apng_chunk_stream_parser_core import apngp_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic csr_write_enable,
   input  logic [16:0] csr_write_data,
   apngp_req_if.sink req,
   apngp_rsp_if.source rsp
);

   logic [16:0] max_frames_ff;
   logic room;
   logic take;
   step_type step;

   always_ff @(posedge clock) begin
      if (reset) max_frames_ff <= MAX_FRAMES_RESET;
      else if (csr_write_enable) max_frames_ff <= csr_write_data;
   end

   assign req.ready = room;
   assign take = req.valid && room;

   apngp_front u_front (
      .clock(clock), .reset(reset), .max_frames(max_frames_ff),
      .in_valid(take), .in_byte(req.file_byte), .in_eof(req.end_of_file),
      .step_out(step)
   );

   apngp_queue u_queue (
      .clock(clock), .reset(reset), .push(step), .room(room),
      .out_valid(rsp.valid), .out_ready(rsp.ready), .out_word(rsp.payload)
   );

endmodule

// ===== hdl/apngp_checker.sv =====
// Port-level checks for the parser core, bound to the top level.
// Depends on apngp_pkg.
module apngp_checker import apngp_pkg::*; (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic req_eof,
   input logic rsp_valid,
   input logic rsp_ready,
   input result_type rsp_payload
);

   a_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.event_kind <= EV_SUMMARY) else $error("bad event kind");
   a_sum_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.event_kind == EV_SUMMARY |-> rsp_payload.run_last)
      else $error("summary not last");
   a_stat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.event_kind != EV_SUMMARY |-> rsp_payload.parse_status == ST_OK)
      else $error("status outside summary");
   a_eof_out: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_eof |=> rsp_valid) else $error("no summary");
   // hold a stalled word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled word changed");

endmodule

bind apng_chunk_stream_parser_core apngp_checker u_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready), .req_eof(req.end_of_file),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_payload(rsp.payload)
);

// ===== test/apng_chunk_stream_parser_core_test.sv =====
// Self-checking testbench for apng_chunk_stream_parser_core: generated APNG files
// with random content and faults go in, and the results are checked against a built-in predictor.
// Depends on apngp_pkg, apngp_if and the parser core.
`timescale 1ns / 1ps

module apng_chunk_stream_parser_core_test;
   import apngp_pkg::*;

   localparam logic [7:0] FL_IHDR = 8'h01;
   localparam logic [7:0] FL_ACTL = 8'h02;
   localparam logic [7:0] FL_IDAT = 8'h04;
   localparam logic [7:0] FL_IDAT_FRAME = 8'h08;
   localparam logic [7:0] FL_HAS_DATA = 8'h10;
   localparam logic [7:0] FL_MISSING = 8'h20;
   localparam logic [7:0] FL_DONE = 8'h40;
   localparam logic [7:0] FL_FWD = 8'h80;
   localparam logic [7:0] SIGNATURE [8] = '{SIG_B0, SIG_B1, SIG_B2, SIG_B3,
                                            SIG_B4, SIG_B5, SIG_B6, SIG_B7};
   localparam logic [31:0] T_TEXT = 32'h74455874;

   typedef enum int {
      F_NONE, F_SHORT, F_NOISE, F_FLIP, F_TRUNC, F_SEQ, F_OPS, F_EMPTY,
      F_COUNT, F_NOACTL, F_NOIHDR, F_AFTER_END, F_BOUNDS
   } fault_type;

   typedef struct packed {
      logic [7:0] file_byte;
      logic end_of_file;
   } byte_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [16:0] csr_write_data = '0;

   apngp_req_if req ();
   apngp_rsp_if rsp ();

   apng_chunk_stream_parser_core i_dut (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data),
      .req(req.sink),
      .rsp(rsp.source)
   );

   always #5 clock = ~clock;

   byte_word_type pending_bytes[$];
   result_type expected_results[$];
   logic [7:0] file_bytes[$];
   logic [7:0] chunk_body[$];
   int mismatches = 0;
   int bytes_sent = 0;
   logic byte_taken = 1'b0;

   // predictor state
   logic [16:0] max_frames;
   int sig_index;
   longint unsigned chunk_pos;
   logic [31:0] chunk_len, chunk_kind, field_shift;
   logic [63:0] frame_size, frame_offsets, delay_ops, canvas;
   logic [31:0] plays, declared, next_seq;
   logic [16:0] frames_seen;
   logic [7:0] flags;
   logic [1:0] first_error;
   result_type step_results[2];
   int step_count;

   function automatic bit has(logic [7:0] f);
      return (flags & f) != 0;
   endfunction

   function automatic void set_fl(logic [7:0] f, bit v);
      if (v) flags = flags | f;
      else flags = flags & ~f;
   endfunction

   function automatic void clear_parse();
      sig_index = 0; chunk_pos = 0; chunk_len = 0; chunk_kind = 0; field_shift = 0;
      frame_size = 0; frame_offsets = 0; delay_ops = 0; canvas = 0; plays = 0;
      declared = 0; next_seq = 0; frames_seen = 0; flags = 0; first_error = ST_OK;
   endfunction

   function automatic void close_frame_header();
      longint unsigned w, h, x, y, cw, ch, dsp, bld;
      result_type r;
      w = frame_size[63:32]; h = frame_size[31:0];
      x = frame_offsets[63:32]; y = frame_offsets[31:0];
      cw = canvas[63:32]; ch = canvas[31:0];
      dsp = delay_ops[15:8]; bld = delay_ops[7:0];
      if (w == 0 || h == 0 || dsp > 2 || bld > 1 || x + w > cw || y + h > ch) begin
         first_error = ST_CORRUPT;
         return;
      end
      if (!has(FL_IDAT) && (x != 0 || y != 0 || w != cw || h != ch)) begin
         first_error = ST_CORRUPT;
         return;
      end
      if (frames_seen >= declared) begin
         first_error = ST_CORRUPT;
         return;
      end
      if (frames_seen > 0 && !has(FL_HAS_DATA)) set_fl(FL_MISSING, 1);
      set_fl(FL_HAS_DATA, 0);
      set_fl(FL_IDAT_FRAME, !has(FL_IDAT));
      r = '0;
      r.event_kind = EV_DESC;
      r.frame_number = frames_seen;
      r.region_width = 32'(w); r.region_height = 32'(h);
      r.offset_x = 32'(x); r.offset_y = 32'(y);
      r.delay_numerator = delay_ops[47:32];
      r.delay_denominator = delay_ops[31:16];
      r.dispose_and_blend = 3'(dsp * 2 + bld);
      step_results[step_count++] = r;
      frames_seen = 17'(frames_seen + 17'd1);
   endfunction

   function automatic void take_field_byte(longint unsigned d);
      logic [31:0] v;
      v = field_shift;
      if (!has(FL_IHDR)) begin
         if (d == 3) canvas[63:32] = v;
         if (d == 7) begin
            canvas[31:0] = v;
            if (canvas[63:32] == 0 || v == 0) first_error = ST_CORRUPT;
            else set_fl(FL_IHDR, 1);
         end
      end else if (chunk_kind == T_ACTL) begin
         if (d == 3) declared = v;
         if (d == 7) begin
            plays = v;
            if (declared == 0 || declared > max_frames) first_error = ST_CORRUPT;
            else set_fl(FL_ACTL, 1);
         end
      end else if (chunk_kind == T_FCTL) begin
         case (d)
            7: frame_size[63:32] = v;
            11: frame_size[31:0] = v;
            15: frame_offsets[63:32] = v;
            19: frame_offsets[31:0] = v;
            21: delay_ops = {16'd0, v[15:0], 32'd0};
            23: delay_ops[31:16] = v[15:0];
            24: delay_ops[15:8] = v[7:0];
            25: begin
               delay_ops[7:0] = v[7:0];
               close_frame_header();
            end
            default: ;
         endcase
      end
   endfunction

   function automatic void check_chunk_header();
      bit fwd;
      if (!has(FL_IHDR)) begin
         if (chunk_kind != T_IHDR || chunk_len != IHDR_LEN) first_error = ST_CORRUPT;
      end else if (chunk_kind == T_ACTL) begin
         if (chunk_len != ACTL_LEN || has(FL_ACTL) || has(FL_IDAT)) first_error = ST_CORRUPT;
      end else if (chunk_kind == T_FCTL) begin
         if (!has(FL_ACTL) || chunk_len != FCTL_LEN || field_shift != next_seq)
            first_error = ST_CORRUPT;
         else next_seq = next_seq + 32'd1;
      end else if (chunk_kind == T_IDAT) begin
         fwd = has(FL_ACTL) && has(FL_IDAT_FRAME) && frames_seen > 0;
         set_fl(FL_IDAT, 1);
         if (fwd) set_fl(FL_HAS_DATA, 1);
         set_fl(FL_IDAT_FRAME, has(FL_IDAT_FRAME) && frames_seen == 1);
      end else if (chunk_kind == T_FDAT) begin
         if (!(has(FL_ACTL) && has(FL_IDAT) && chunk_len >= 4 && frames_seen > 0 &&
               !has(FL_IDAT_FRAME)))
            first_error = ST_CORRUPT;
         else if (field_shift != next_seq) first_error = ST_CORRUPT;
         else begin
            next_seq = next_seq + 32'd1;
            set_fl(FL_HAS_DATA, 1);
            set_fl(FL_FWD, 1);
         end
      end
   endfunction

   function automatic void take_chunk_byte(logic [7:0] b);
      longint unsigned pos;
      result_type r;
      pos = chunk_pos;
      field_shift = {field_shift[23:0], b};
      if (pos == 3) chunk_len = field_shift;
      if (pos == 7) begin
         chunk_kind = field_shift;
         set_fl(FL_FWD, has(FL_IHDR) && chunk_kind == T_IDAT && has(FL_ACTL) &&
                has(FL_IDAT_FRAME) && frames_seen > 0);
      end
      if (pos >= 8 && pos < 8 + longint'(chunk_len)) begin
         if (has(FL_FWD)) begin
            r = '0;
            r.event_kind = EV_DATA;
            r.frame_number = 17'(frames_seen - 17'd1);
            r.payload_byte = b;
            step_results[step_count++] = r;
         end else begin
            take_field_byte(pos - 8);
         end
      end
      chunk_pos = pos + 1;
      if (first_error == ST_OK && chunk_pos == 12) check_chunk_header();
      if (first_error == ST_OK && chunk_pos == longint'(chunk_len) + 12) begin
         if (has(FL_IHDR) && chunk_kind == T_IEND) set_fl(FL_DONE, 1);
         set_fl(FL_FWD, 0);
         chunk_pos = 0;
      end
   endfunction

   function automatic logic [1:0] file_status();
      if (first_error != ST_OK) return first_error;
      if (sig_index < 8) return ST_UNSUP;
      if (chunk_pos >= 12) return ST_CORRUPT;
      if (!has(FL_IHDR)) return ST_CORRUPT;
      if (!has(FL_ACTL)) return ST_UNSUP;
      if (!has(FL_IDAT) || frames_seen != declared) return ST_CORRUPT;
      if (has(FL_MISSING) || (frames_seen > 0 && !has(FL_HAS_DATA))) return ST_CORRUPT;
      return ST_OK;
   endfunction

   // work out the results of one accepted word and queue them
   function automatic void predict_parse(logic [7:0] b, logic eof);
      result_type r;
      step_count = 0;
      if (first_error == ST_OK && !has(FL_DONE)) begin
         if (sig_index < 8) begin
            if (b != SIGNATURE[sig_index]) first_error = ST_UNSUP;
            else sig_index++;
         end else begin
            take_chunk_byte(b);
         end
      end
      if (eof) begin
         r = '0;
         r.event_kind = EV_SUMMARY;
         r.frame_number = frames_seen;
         r.region_width = canvas[63:32];
         r.region_height = canvas[31:0];
         r.offset_x = plays;
         r.parse_status = file_status();
         step_results[step_count++] = r;
         clear_parse();
      end
      if (step_count > 0) step_results[step_count - 1].run_last = 1'b1;
      for (int i = 0; i < step_count; i++)
         expected_results.insert(expected_results.size(), step_results[i]);
   endfunction

   task automatic report(string field, longint unsigned got, longint unsigned want);
      mismatches++;
      if (mismatches <= 60)
         $display("%0t: mismatch in %s: got %0h, expected %0h", $realtime, field, got, want);
   endtask

   task automatic check_result(result_type got);
      result_type want;
      if (expected_results.size() == 0) begin
         report("unexpected result", got.event_kind, 0);
         return;
      end
      want = expected_results.pop_front();
      if (got.event_kind !== want.event_kind) report("event_kind", got.event_kind, want.event_kind);
      if (got.frame_number !== want.frame_number)
         report("frame_number", got.frame_number, want.frame_number);
      if (got.region_width !== want.region_width)
         report("region_width", got.region_width, want.region_width);
      if (got.region_height !== want.region_height)
         report("region_height", got.region_height, want.region_height);
      if (got.offset_x !== want.offset_x) report("offset_x", got.offset_x, want.offset_x);
      if (got.offset_y !== want.offset_y) report("offset_y", got.offset_y, want.offset_y);
      if (got.delay_numerator !== want.delay_numerator)
         report("delay_numerator", got.delay_numerator, want.delay_numerator);
      if (got.delay_denominator !== want.delay_denominator)
         report("delay_denominator", got.delay_denominator, want.delay_denominator);
      if (got.dispose_and_blend !== want.dispose_and_blend)
         report("dispose_and_blend", got.dispose_and_blend, want.dispose_and_blend);
      if (got.payload_byte !== want.payload_byte)
         report("payload_byte", got.payload_byte, want.payload_byte);
      if (got.parse_status !== want.parse_status)
         report("parse_status", got.parse_status, want.parse_status);
      if (got.run_last !== want.run_last) report("run_last", got.run_last, want.run_last);
   endtask

   // monitor: compare before predicting, since a word's results pass through the result queue registers first
   always @(posedge clock) begin
      byte_taken <= req.valid && req.ready && !reset;
      if (!reset) begin
         if (rsp.valid && rsp.ready) check_result(rsp.payload);
         if (csr_write_enable) max_frames = csr_write_data;
         if (req.valid && req.ready) predict_parse(req.file_byte, req.end_of_file);
      end
   end

   // sender: bursts of random length with random gaps
   int burst_left = 0;
   int gap_left = 0;
   always @(negedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
      end else if (req.valid && !byte_taken) begin
         // hold the word until taken
      end else if (gap_left > 0) begin
         gap_left--;
         req.valid <= 1'b0;
      end else if (pending_bytes.size() > 0) begin
         req.valid <= 1'b1;
         {req.file_byte, req.end_of_file} <= pending_bytes.pop_front();
         if (burst_left > 0) begin
            burst_left--;
         end else begin
            burst_left = $urandom_range(0, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         end
      end else begin
         req.valid <= 1'b0;
      end
   end

   // receiver: stalls in modes of random length
   int ready_mode = 0;
   int ready_run = 0;
   always @(negedge clock) begin
      if (ready_run == 0) begin
         ready_mode = $urandom_range(0, 2);
         ready_run = $urandom_range(10, 80);
      end
      ready_run--;
      case (ready_mode)
         0: rsp.ready <= 1'b1;
         1: rsp.ready <= 1'($urandom_range(0, 1));
         default: rsp.ready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   task automatic put32(logic [31:0] v);
      for (int i = 3; i >= 0; i--) chunk_body.insert(chunk_body.size(), v[i*8 +: 8]);
   endtask

   task automatic add_chunk(logic [31:0] kind);
      logic [31:0] len;
      len = chunk_body.size();
      for (int i = 3; i >= 0; i--) file_bytes.insert(file_bytes.size(), len[i*8 +: 8]);
      for (int i = 3; i >= 0; i--) file_bytes.insert(file_bytes.size(), kind[i*8 +: 8]);
      foreach (chunk_body[i]) file_bytes.insert(file_bytes.size(), chunk_body[i]);
      repeat (4) file_bytes.insert(file_bytes.size(), 8'($urandom));
      chunk_body.delete();
   endtask

   task automatic add_image_chunk(logic [31:0] kind, logic [31:0] seq);
      int n;
      n = $urandom_range(0, 6);
      if (kind == T_FDAT) put32(seq);
      repeat (n) chunk_body.insert(chunk_body.size(), 8'($urandom));
      add_chunk(kind);
   endtask

   task automatic build_file(fault_type fault);
      int frames, bad_frame, k;
      bit lead_image;
      logic [31:0] cw, ch, w, h, x, y, seq, count;
      file_bytes.delete();
      chunk_body.delete();
      if (fault == F_NOISE) begin
         if ($urandom_range(0, 1)) for (int i = 0; i < $urandom_range(1, 7); i++)
            file_bytes.insert(file_bytes.size(), SIGNATURE[i]);
         repeat ($urandom_range(1, 16)) file_bytes.insert(file_bytes.size(), 8'($urandom));
         return;
      end
      foreach (SIGNATURE[i]) file_bytes.insert(file_bytes.size(), SIGNATURE[i]);
      if (fault == F_SHORT) begin
         k = $urandom_range(1, 7);
         file_bytes = file_bytes[0:k-1];
         return;
      end
      frames = $urandom_range(1, 4);
      bad_frame = $urandom_range(0, frames - 1);
      lead_image = $urandom_range(0, 1);
      if ($urandom_range(0, 4) == 0) begin
         cw = $urandom | 32'h1;
         ch = $urandom | 32'h1;
      end else begin
         cw = $urandom_range(1, 40);
         ch = $urandom_range(1, 40);
      end
      if (fault == F_BOUNDS && bad_frame == 0 && $urandom_range(0, 1)) cw = 0;
      if (fault != F_NOIHDR) begin
         put32(cw);
         put32(ch);
         repeat (5) chunk_body.insert(chunk_body.size(), 8'($urandom));
         add_chunk(T_IHDR);
      end
      if (fault == F_NOACTL) begin
         add_image_chunk(T_IDAT, 0);
         add_chunk(T_IEND);
         return;
      end
      count = frames;
      if (fault == F_COUNT) count = $urandom_range(0, 1) ? frames + 1 : frames - 1;
      put32(count);
      put32($urandom_range(0, 1) ? $urandom : $urandom_range(0, 3));
      add_chunk(T_ACTL);
      seq = 0;
      if (!lead_image) add_image_chunk(T_IDAT, 0);
      for (int f = 0; f < frames; f++) begin
         if (f == 0 && lead_image) begin
            w = cw; h = ch; x = 0; y = 0;
         end else begin
            w = $urandom_range(1, cw);
            h = $urandom_range(1, ch);
            x = $urandom_range(0, cw - w);
            y = $urandom_range(0, ch - h);
         end
         if (fault == F_BOUNDS && f == bad_frame) begin
            if ($urandom_range(0, 1)) w = w + 1;
            else h = 0;
         end
         put32((fault == F_SEQ && f == bad_frame) ? seq + 1 : seq);
         seq++;
         put32(w); put32(h); put32(x); put32(y);
         repeat (4) chunk_body.insert(chunk_body.size(), 8'($urandom));
         if (fault == F_OPS && f == bad_frame) begin
            chunk_body.insert(chunk_body.size(), 8'($urandom_range(3, 255)));
            chunk_body.insert(chunk_body.size(), 8'($urandom_range(0, 255)));
         end else begin
            chunk_body.insert(chunk_body.size(), 8'($urandom_range(0, 2)));
            chunk_body.insert(chunk_body.size(), 8'($urandom_range(0, 1)));
         end
         add_chunk(T_FCTL);
         if ($urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(0, 3)) chunk_body.insert(chunk_body.size(), 8'($urandom));
            add_chunk(T_TEXT);
         end
         if (fault == F_EMPTY && f == bad_frame) continue;
         repeat ($urandom_range(1, 2)) begin
            if (f == 0 && lead_image) begin
               add_image_chunk(T_IDAT, 0);
            end else begin
               add_image_chunk(T_FDAT, seq);
               seq++;
            end
         end
      end
      add_chunk(T_IEND);
      if (fault == F_AFTER_END) add_image_chunk(T_FDAT, seq);
      if (fault == F_FLIP) begin
         k = $urandom_range(8, file_bytes.size() - 1);
         file_bytes[k] = file_bytes[k] ^ 8'($urandom_range(1, 255));
      end
      if (fault == F_TRUNC) begin
         k = $urandom_range(9, file_bytes.size() - 1);
         file_bytes = file_bytes[0:k-1];
      end
   endtask

   task automatic send_file(fault_type fault);
      build_file(fault);
      foreach (file_bytes[i])
         pending_bytes.insert(pending_bytes.size(),
                              '{file_bytes[i], i == file_bytes.size() - 1});
      bytes_sent += file_bytes.size();
   endtask

   // hold off until the block has drained, then write the register
   task automatic write_max_frames(logic [16:0] value);
      while (pending_bytes.size() > 0 || req.valid || expected_results.size() > 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      req.valid = 1'b0;
      req.file_byte = '0;
      req.end_of_file = 1'b0;
      rsp.ready = 1'b0;
      clear_parse();
      max_frames = MAX_FRAMES_RESET;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: at least one file per fault kind, with the register at 1 and at its reset value
      send_file(F_NONE);
      send_file(F_SHORT);
      send_file(F_NOISE);
      write_max_frames(17'd1);
      send_file(F_NONE);
      send_file(F_COUNT);
      write_max_frames(MAX_FRAMES_RESET);
      for (int f = F_FLIP; f <= F_BOUNDS; f++) send_file(fault_type'(f));

      // random: clean files in 45 of 100 draws, the rest with one fault each
      while (bytes_sent < 1250) begin
         if ($urandom_range(0, 99) < 45) send_file(F_NONE);
         else send_file(fault_type'($urandom_range(F_SHORT, F_BOUNDS)));
         if ($urandom_range(0, 5) == 0) begin
            case ($urandom_range(0, 3))
               0: write_max_frames(17'd1);
               1: write_max_frames(MAX_FRAMES_RESET);
               2: write_max_frames(17'($urandom_range(2, 4)));
               default: write_max_frames(17'($urandom_range(1, 100000)));
            endcase
         end
      end

      while (pending_bytes.size() > 0 || req.valid || expected_results.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (expected_results.size() > 0) report("results missing", expected_results.size(), 0);
      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/apngp_pkg.sv
hdl/apngp_if.sv
hdl/apngp_front.sv
hdl/apngp_queue.sv
hdl/apng_chunk_stream_parser_core.sv
hdl/apngp_checker.sv
test/apng_chunk_stream_parser_core_test.sv
